// ===== rtl/nfa_pkg.sv =====
// Shared types, constants and helper functions of the next-free address allocator.
package nfa_pkg;

  // Pool geometry. The tree memory keeps one row per inner tree node, holding
  // the full flags of that node's two children.
  localparam int ADDR_BITS = 12;
  localparam int NODE_W    = ADDR_BITS + 1;
  localparam int CNT_W     = ADDR_BITS + 1;
  localparam int ROWS      = 1 << ADDR_BITS;
  localparam int CFG_W     = 4;

  localparam logic [CFG_W-1:0] ACTIVE_BITS_RST = CFG_W'(ADDR_BITS);

  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [ADDR_BITS-1:0] row_t;
  typedef logic [NODE_W-1:0]    node_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [1:0]           pair_t;

  // Operation codes.
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // Result status codes.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_NOT_ALLOC = 2'd2;

  // Root row of the tree memory.
  localparam row_t ROOT_ROW = row_t'(1);

  typedef struct packed {
    logic  func;
    addr_t addr;
  } in_item_t;

  typedef struct packed {
    addr_t      granted_addr;
    logic [1:0] status;
    cnt_t       allocated_count;
  } out_item_t;

  // One access slot of the tree memory: one write and one read per cycle.
  typedef struct packed {
    logic  we;
    row_t  waddr;
    pair_t wdata;
    row_t  raddr;
  } mem_req_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LEAF,
    ST_CLIMB,
    ST_DESC,
    ST_UPDATE,
    ST_FINISH
  } state_t;

  // Mask of the address bits in use; the register value is clamped to 1..ADDR_BITS.
  function automatic addr_t pool_mask(logic [CFG_W-1:0] bits);
    int    eff;
    addr_t m;
    eff = int'(bits);
    if (eff < 1) eff = 1;
    if (eff > ADDR_BITS) eff = ADDR_BITS;
    for (int i = 0; i < ADDR_BITS; i++) begin
      m[i] = (i < eff);
    end
    return m;
  endfunction

  // Tree memory row that holds the full flag of the leaf of an address.
  function automatic row_t leaf_row(addr_t a);
    node_t n;
    n = {1'b1, a};
    return n[NODE_W-1:1];
  endfunction

endpackage

// ===== rtl/next_free_address_allocator.sv =====
// Top level of the next-free address allocator: config register, result register, walker, memory.
//
//   Port group   Direction   Payload           Handshake
//   in_          input       nfa_pkg::in_item_t   in_valid / in_stall
//   out_         output      nfa_pkg::out_item_t  out_valid / out_stall
//   cfg_         input       active_bits (4b)     cfg_we, no wait
//
// After reset a clearing pass writes all 4096 tree rows, one per cycle, with in_stall high.
// A beat then runs from a free of a free address, which only reads its leaf row, to an
// allocate that climbs to the top and descends again; the climb and the descent each take
// one read of the single read port per tree level, and the path update one more per level.
// One beat is in work at a time; a finished result waits in the output register while the
// next beat is taken, and the walker holds its result until that register is free.
module next_free_address_allocator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  nfa_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output nfa_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [nfa_pkg::CFG_W-1:0]     cfg_wdata
);

  logic [nfa_pkg::CFG_W-1:0] active_bits_r;
  logic                      out_valid_r, out_valid_nxt;
  nfa_pkg::out_item_t        out_data_r;

  nfa_pkg::addr_t            mask;
  logic                      res_room;
  logic                      res_done;
  nfa_pkg::out_item_t        res;
  nfa_pkg::mem_req_t         req;
  nfa_pkg::pair_t            rdata;

  // Pool size register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_bits_r <= nfa_pkg::ACTIVE_BITS_RST;
    end else if (cfg_we) begin
      active_bits_r <= cfg_wdata;
    end
  end

  assign mask = nfa_pkg::pool_mask(active_bits_r);

  // Output register: free when empty or when its beat leaves this cycle.
  assign res_room = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_done) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_done) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  nfa_walker u_walker (
    .clk      (clk),
    .rst_n    (rst_n),
    .mask     (mask),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .res_room (res_room),
    .res_done (res_done),
    .res      (res),
    .req      (req),
    .rdata    (rdata)
  );

  nfa_tree_ram u_tree_ram (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

endmodule

// ===== rtl/nfa_tree_ram.sv =====
// Tree memory: one row of two sibling full flags per inner node, registered read.
module nfa_tree_ram (
  input  logic              clk,
  input  nfa_pkg::mem_req_t req,
  output nfa_pkg::pair_t    rdata
);

  nfa_pkg::pair_t mem [nfa_pkg::ROWS];
  nfa_pkg::pair_t rdata_r;

  // One write port and one read port, both synchronous.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_r <= mem[req.raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/nfa_walker.sv =====
// Tree walker: clears the memory, then searches and updates the tree per beat.
module nfa_walker (
  input  logic                clk,
  input  logic                rst_n,
  input  nfa_pkg::addr_t      mask,
  input  logic                in_valid,
  input  nfa_pkg::in_item_t   in_data,
  output logic                in_stall,
  input  logic                res_room,
  output logic                res_done,
  output nfa_pkg::out_item_t  res,
  output nfa_pkg::mem_req_t   req,
  input  nfa_pkg::pair_t      rdata
);

  localparam int A = nfa_pkg::ADDR_BITS;

  nfa_pkg::state_t state_r, state_nxt;
  nfa_pkg::row_t   clr_r, clr_nxt;
  nfa_pkg::addr_t  a_r, a_nxt;
  logic            func_r, func_nxt;
  nfa_pkg::node_t  idx_r, idx_nxt;
  nfa_pkg::row_t   row_r, row_nxt;
  logic            pos_r, pos_nxt;
  logic            bit_r, bit_nxt;
  nfa_pkg::addr_t  gaddr_r, gaddr_nxt;
  logic [1:0]      status_r, status_nxt;
  nfa_pkg::cnt_t   count_r, count_nxt;

  logic            accept;
  nfa_pkg::row_t   cur_leaf_row;
  logic            leaf_bit;
  logic            leaf_sib_free;
  nfa_pkg::addr_t  sib_addr;
  logic            climb_hit;
  nfa_pkg::node_t  idx_up;
  logic            desc_sel;
  nfa_pkg::node_t  desc_child;
  logic            desc_at_leaf;
  nfa_pkg::addr_t  desc_addr;

  logic            ap_en;
  logic            ap_first;
  nfa_pkg::row_t   ap_row;
  logic            ap_pos;
  logic            ap_bit;
  nfa_pkg::addr_t  ap_addr;
  nfa_pkg::pair_t  ap_wdata;

  assign accept = in_valid && !in_stall;
  assign in_stall = (state_r != nfa_pkg::ST_IDLE);

  // Decode of the row that just came back from the memory.
  assign cur_leaf_row  = nfa_pkg::leaf_row(a_r);
  assign leaf_bit      = rdata[a_r[0]];
  assign leaf_sib_free = !a_r[0] && !rdata[1];
  assign sib_addr      = a_r | nfa_pkg::addr_t'(1);
  assign climb_hit     = !idx_r[0] && !rdata[1];
  assign idx_up        = idx_r >> 1;
  assign desc_sel      = rdata[0];
  assign desc_child    = {idx_r[A-1:0], desc_sel};
  assign desc_at_leaf  = idx_r[A-1];
  assign desc_addr     = desc_child[A-1:0];

  // Selection of the row to modify: a leaf flip, or one step up the path.
  always_comb begin
    ap_en    = 1'b0;
    ap_first = 1'b0;
    ap_row   = row_r;
    ap_pos   = pos_r;
    ap_bit   = bit_r;
    ap_addr  = a_r;
    case (state_r)
      nfa_pkg::ST_LEAF: begin
        ap_row   = cur_leaf_row;
        ap_pos   = a_r[0];
        ap_first = 1'b1;
        if (func_r == nfa_pkg::FUNC_FREE) begin
          ap_en  = leaf_bit;
          ap_bit = 1'b0;
        end else if (!leaf_bit) begin
          ap_en  = 1'b1;
          ap_bit = 1'b1;
        end else begin
          ap_en   = leaf_sib_free && ((sib_addr & ~mask) == '0);
          ap_pos  = 1'b1;
          ap_bit  = 1'b1;
          ap_addr = sib_addr;
        end
      end
      nfa_pkg::ST_DESC: begin
        ap_en    = desc_at_leaf && ((desc_addr & ~mask) == '0);
        ap_first = 1'b1;
        ap_row   = idx_r[A-1:0];
        ap_pos   = desc_sel;
        ap_bit   = 1'b1;
        ap_addr  = desc_addr;
      end
      nfa_pkg::ST_UPDATE: begin
        ap_en = 1'b1;
      end
      default: begin
        ap_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    ap_wdata         = rdata;
    ap_wdata[ap_pos] = ap_bit;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      nfa_pkg::ST_CLEAR: begin
        if (clr_r == '1) state_nxt = nfa_pkg::ST_IDLE;
      end
      nfa_pkg::ST_IDLE: begin
        if (accept) state_nxt = nfa_pkg::ST_LEAF;
      end
      nfa_pkg::ST_LEAF: begin
        if (ap_en) begin
          state_nxt = (ap_row == nfa_pkg::ROOT_ROW) ? nfa_pkg::ST_FINISH : nfa_pkg::ST_UPDATE;
        end else if (func_r == nfa_pkg::FUNC_FREE || leaf_sib_free ||
                     cur_leaf_row == nfa_pkg::ROOT_ROW) begin
          state_nxt = nfa_pkg::ST_FINISH;
        end else begin
          state_nxt = nfa_pkg::ST_CLIMB;
        end
      end
      nfa_pkg::ST_CLIMB: begin
        if (climb_hit) begin
          state_nxt = nfa_pkg::ST_DESC;
        end else if (idx_up == nfa_pkg::node_t'(1)) begin
          state_nxt = nfa_pkg::ST_FINISH;
        end
      end
      nfa_pkg::ST_DESC: begin
        if (ap_en) begin
          state_nxt = (ap_row == nfa_pkg::ROOT_ROW) ? nfa_pkg::ST_FINISH : nfa_pkg::ST_UPDATE;
        end else if (desc_at_leaf) begin
          state_nxt = nfa_pkg::ST_FINISH;
        end
      end
      nfa_pkg::ST_UPDATE: begin
        if (ap_row == nfa_pkg::ROOT_ROW) state_nxt = nfa_pkg::ST_FINISH;
      end
      nfa_pkg::ST_FINISH: begin
        if (res_room) state_nxt = nfa_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = nfa_pkg::ST_IDLE;
      end
    endcase
  end

  // Memory requests and datapath updates.
  always_comb begin
    req        = '0;
    res_done   = 1'b0;
    clr_nxt    = clr_r;
    a_nxt      = a_r;
    func_nxt   = func_r;
    idx_nxt    = idx_r;
    row_nxt    = row_r;
    pos_nxt    = pos_r;
    bit_nxt    = bit_r;
    gaddr_nxt  = gaddr_r;
    status_nxt = status_r;
    count_nxt  = count_r;
    case (state_r)
      nfa_pkg::ST_CLEAR: begin
        req.we    = 1'b1;
        req.waddr = clr_r;
        clr_nxt   = clr_r + nfa_pkg::row_t'(1);
      end
      nfa_pkg::ST_IDLE: begin
        req.raddr = nfa_pkg::leaf_row(in_data.addr & mask);
        if (accept) begin
          a_nxt      = in_data.addr & mask;
          func_nxt   = in_data.func;
          status_nxt = nfa_pkg::STATUS_OK;
          gaddr_nxt  = '0;
        end
      end
      nfa_pkg::ST_LEAF: begin
        if (!ap_en) begin
          if (func_r == nfa_pkg::FUNC_FREE) begin
            status_nxt = nfa_pkg::STATUS_NOT_ALLOC;
          end else if (leaf_sib_free || cur_leaf_row == nfa_pkg::ROOT_ROW) begin
            status_nxt = nfa_pkg::STATUS_FULL;
          end else begin
            idx_nxt   = {1'b0, cur_leaf_row};
            req.raddr = cur_leaf_row >> 1;
          end
        end
      end
      nfa_pkg::ST_CLIMB: begin
        if (climb_hit) begin
          idx_nxt   = idx_r + nfa_pkg::node_t'(1);
          req.raddr = idx_nxt[A-1:0];
        end else begin
          idx_nxt   = idx_up;
          req.raddr = idx_up[A:1];
          if (idx_up == nfa_pkg::node_t'(1)) status_nxt = nfa_pkg::STATUS_FULL;
        end
      end
      nfa_pkg::ST_DESC: begin
        if (!desc_at_leaf) begin
          idx_nxt   = desc_child;
          req.raddr = desc_child[A-1:0];
        end else if (!ap_en) begin
          status_nxt = nfa_pkg::STATUS_FULL;
        end
      end
      nfa_pkg::ST_FINISH: begin
        res_done = res_room;
      end
      default: begin
        req = '0;
      end
    endcase

    // Write the modified row and fetch its parent for the next step up.
    if (ap_en) begin
      req.we    = 1'b1;
      req.waddr = ap_row;
      req.wdata = ap_wdata;
      req.raddr = ap_row >> 1;
      row_nxt   = ap_row >> 1;
      pos_nxt   = ap_row[0];
      bit_nxt   = &ap_wdata;
      if (ap_first) begin
        if (func_r == nfa_pkg::FUNC_FREE) begin
          count_nxt = count_r - nfa_pkg::cnt_t'(1);
        end else begin
          count_nxt = count_r + nfa_pkg::cnt_t'(1);
          gaddr_nxt = ap_addr;
        end
      end
    end
  end

  assign res.granted_addr    = gaddr_r;
  assign res.status          = status_r;
  assign res.allocated_count = count_r;

  // Control state is reset; the walk registers need none.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nfa_pkg::ST_CLEAR;
      clr_r   <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r      <= a_nxt;
    func_r   <= func_nxt;
    idx_r    <= idx_nxt;
    row_r    <= row_nxt;
    pos_r    <= pos_nxt;
    bit_r    <= bit_nxt;
    gaddr_r  <= gaddr_nxt;
    status_r <= status_nxt;
  end

  // The allocated count can never pass the pool size.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= nfa_pkg::cnt_t'(nfa_pkg::ROWS))
    else $error("allocated count exceeds pool size");

  // The clearing pass must cover every row before the first beat is taken.
  a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == nfa_pkg::ST_IDLE && $past(state_r) == nfa_pkg::ST_CLEAR) |->
      $past(clr_r) == '1)
    else $error("clearing pass left early");

  // A read-modify-write step never reads the row it is writing.
  a_no_rw_same_row: assert property (@(posedge clk) disable iff (!rst_n)
    (req.we && state_r != nfa_pkg::ST_CLEAR) |-> req.waddr != req.raddr)
    else $error("read and write of the same row in one cycle");

  // A successful allocate grants an address inside the pool.
  a_grant_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    (res_done && func_r == nfa_pkg::FUNC_ALLOC && res.status == nfa_pkg::STATUS_OK) |->
      (res.granted_addr & ~mask) == '0)
    else $error("granted address outside the pool");

endmodule
